// ----- rtl/sha256_pkg.sv -----
// Shared types, round constants and mixing functions for the SHA-256 engine.
`default_nettype none

package sha256_pkg;

  // Input beat: message word, byte count of the final beat, end-of-message mark
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } in_beat_t;

  // Output beat: one digest word with its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  localparam int unsigned NumRounds  = 64;
  localparam int unsigned NumWords   = 16;
  localparam int unsigned NumChain   = 8;
  localparam int unsigned RoundW     = $clog2(NumRounds);
  localparam int unsigned FillW      = $clog2(NumWords);
  localparam int unsigned OutIdxW    = $clog2(NumChain);

  localparam logic [31:0] PAD_MARK   = 32'h8000_0000;
  localparam logic [2:0]  BYTES_FULL = 3'd4;
  // Final-block byte position from which the length no longer fits
  localparam logic [6:0]  LEN_LIMIT  = 7'd56;

  localparam logic [31:0] INIT_HASH [NumChain] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Sigma on the a word: ror 2, 13, 22
  function automatic logic [31:0] big_sigma0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Sigma on the e word: ror 6, 11, 25
  function automatic logic [31:0] big_sigma1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Schedule sigma: ror 7, 18, shr 3
  function automatic logic [31:0] small_sigma0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Schedule sigma: ror 17, 19, shr 10
  function automatic logic [31:0] small_sigma1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Keep the valid top bytes of the final word and place the 0x80 marker after them when fewer than four are valid
  function automatic logic [31:0] tail_word(logic [31:0] data, logic [2:0] nbytes);
    logic [31:0] word;
    case (nbytes)
      3'd0:    word = PAD_MARK;
      3'd1:    word = {data[31:24], 24'h80_0000};
      3'd2:    word = {data[31:16], 16'h8000};
      3'd3:    word = {data[31:8], 8'h80};
      default: word = data;
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sha256_hash_engine_core.sv -----
// SHA-256 engine: message intake, padding, iterative compression and digest readout.
//
// The engine takes the message as big-endian 32-bit words, one beat per cycle while
// ready, and packs them into a 16-word block. Each full block runs through one shared
// round unit that does one of the 64 rounds per cycle, followed by an update step that
// adds the working variables into the chaining state; the input is not ready during the
// rounds and the update. The beat marked last carries 0 to 4 bytes (larger counts act
// as 4); it starts padding: a pad step writes the length, and a second block of rounds
// is spent when 56 or more bytes sit in the final block. The eight digest words then
// leave as eight output beats, index 0 first, the eighth marked last_word, and the
// engine returns to its initial hash values for the next message.
`default_nettype none

module sha256_hash_engine_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire sha256_pkg::in_beat_t in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output sha256_pkg::out_beat_t     out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROUND  = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_PAD    = 5'b01000,
    ST_OUTPUT = 5'b10000
  } state_e;

  localparam logic [sha256_pkg::RoundW-1:0]  LastRound =
    sha256_pkg::RoundW'(sha256_pkg::NumRounds - 1);
  localparam logic [sha256_pkg::FillW-1:0]   LastWord  =
    sha256_pkg::FillW'(sha256_pkg::NumWords - 1);
  localparam logic [sha256_pkg::OutIdxW-1:0] LastOut   =
    sha256_pkg::OutIdxW'(sha256_pkg::NumChain - 1);

  state_e                            state_q, state_d;
  logic [sha256_pkg::RoundW-1:0]     round_q, round_d;
  logic [sha256_pkg::FillW-1:0]      fill_q, fill_d;
  logic [sha256_pkg::OutIdxW-1:0]    out_idx_q, out_idx_d;
  logic [63:0]                       bit_len_q, bit_len_d;
  logic                              msg_end_q, msg_end_d;
  logic                              pad_pending_q, pad_pending_d;
  logic                              pad_mark_q, pad_mark_d;
  logic [31:0]                       h_q [sha256_pkg::NumChain];
  logic [31:0]                       h_d [sha256_pkg::NumChain];
  logic [31:0]                       v_q [sha256_pkg::NumChain];
  logic [31:0]                       v_d [sha256_pkg::NumChain];
  logic [31:0]                       w_q [sha256_pkg::NumWords];
  logic [31:0]                       w_d [sha256_pkg::NumWords];

  logic        in_fire, out_fire;
  logic [2:0]  nbytes;
  logic [6:0]  tail_pos;
  logic        need_extra;
  logic [31:0] t1, t2, w_next;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUTPUT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Drive the digest beat from the chaining state
  assign out_data_o.digest_word = h_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last_word   = (out_idx_q == LastOut);

  // Saturate the final byte count and find where the padding lands
  assign nbytes     = (in_data_i.byte_count > sha256_pkg::BYTES_FULL) ?
                      sha256_pkg::BYTES_FULL : in_data_i.byte_count;
  assign tail_pos   = {1'b0, fill_q, 2'b00} + {4'b0, nbytes};
  assign need_extra = (tail_pos >= sha256_pkg::LEN_LIMIT);

  // Shared round unit and schedule extension
  assign t1 = v_q[7] + sha256_pkg::big_sigma1(v_q[4])
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256_pkg::ROUND_K[round_q] + w_q[0];
  assign t2 = sha256_pkg::big_sigma0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_next = w_q[0] + sha256_pkg::small_sigma0(w_q[1]) + w_q[9]
                + sha256_pkg::small_sigma1(w_q[14]);

  // Sequence intake, rounds, padding and readout
  always_comb begin
    state_d       = state_q;
    round_d       = round_q;
    fill_d        = fill_q;
    out_idx_d     = out_idx_q;
    bit_len_d     = bit_len_q;
    msg_end_d     = msg_end_q;
    pad_pending_d = pad_pending_q;
    pad_mark_d    = pad_mark_q;
    h_d           = h_q;
    v_d           = v_q;
    w_d           = w_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && !in_data_i.last) begin
          w_d[fill_q] = in_data_i.data_word;
          bit_len_d   = bit_len_q + 64'd32;
          fill_d      = fill_q + 1'b1;
          if (fill_q == LastWord) begin
            v_d     = h_q;
            round_d = '0;
            state_d = ST_ROUND;
          end
        end else if (in_fire) begin
          bit_len_d     = bit_len_q + {58'b0, nbytes, 3'b000};
          msg_end_d     = 1'b1;
          pad_pending_d = need_extra;
          pad_mark_d    = (nbytes == sha256_pkg::BYTES_FULL) && (fill_q == LastWord);
          // Write the tail word, the marker after a full word, and zeros beyond
          for (int k = 0; k < sha256_pkg::NumWords; k++) begin
            if (sha256_pkg::FillW'(k) == fill_q) begin
              w_d[k] = sha256_pkg::tail_word(in_data_i.data_word, nbytes);
            end else if (sha256_pkg::FillW'(k) > fill_q) begin
              w_d[k] = ((sha256_pkg::FillW'(k) == fill_q + 1'b1) &&
                        (nbytes == sha256_pkg::BYTES_FULL)) ? sha256_pkg::PAD_MARK : 32'd0;
            end
          end
          if (need_extra) begin
            v_d     = h_q;
            round_d = '0;
            state_d = ST_ROUND;
          end else begin
            state_d = ST_PAD;
          end
        end
      end

      ST_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        // Slide the schedule window by one word
        for (int k = 0; k < sha256_pkg::NumWords - 1; k++) begin
          w_d[k] = w_q[k + 1];
        end
        w_d[sha256_pkg::NumWords - 1] = w_next;
        round_d = round_q + 1'b1;
        if (round_q == LastRound) begin
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        for (int k = 0; k < sha256_pkg::NumChain; k++) begin
          h_d[k] = h_q[k] + v_q[k];
        end
        if (!msg_end_q) begin
          state_d = ST_IDLE;
        end else if (pad_pending_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_OUTPUT;
        end
      end

      ST_PAD: begin
        // After an extra block, start the length block from zeros, with the marker in word 0 after a full final word
        if (pad_pending_q) begin
          for (int k = 0; k < sha256_pkg::NumWords; k++) begin
            w_d[k] = 32'd0;
          end
          w_d[0] = pad_mark_q ? sha256_pkg::PAD_MARK : 32'd0;
        end
        w_d[sha256_pkg::NumWords - 2] = bit_len_q[63:32];
        w_d[sha256_pkg::NumWords - 1] = bit_len_q[31:0];
        pad_pending_d = 1'b0;
        v_d           = h_q;
        round_d       = '0;
        state_d       = ST_ROUND;
      end

      ST_OUTPUT: begin
        if (out_fire) begin
          out_idx_d = out_idx_q + 1'b1;
          if (out_idx_q == LastOut) begin
            h_d       = sha256_pkg::INIT_HASH;
            bit_len_d = '0;
            fill_d    = '0;
            msg_end_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state and chaining values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      round_q       <= '0;
      fill_q        <= '0;
      out_idx_q     <= '0;
      bit_len_q     <= '0;
      msg_end_q     <= 1'b0;
      pad_pending_q <= 1'b0;
      pad_mark_q    <= 1'b0;
      h_q           <= sha256_pkg::INIT_HASH;
    end else begin
      state_q       <= state_d;
      round_q       <= round_d;
      fill_q        <= fill_d;
      out_idx_q     <= out_idx_d;
      bit_len_q     <= bit_len_d;
      msg_end_q     <= msg_end_d;
      pad_pending_q <= pad_pending_d;
      pad_mark_q    <= pad_mark_d;
      h_q           <= h_d;
    end
  end

  // Hold working variables and the block window
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  // Input and output never open at the same time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest beat pending");

  // The 64th round always hands over to the chaining update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) && (round_q == LastRound) |=> (state_q == ST_UPDATE))
    else $error("round sequence did not end in update");

  // A sixteenth full word starts a compression at round zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_data_i.last && (fill_q == LastWord)
      |=> (state_q == ST_ROUND) && (round_q == '0))
    else $error("full block did not start compression");

  // The last digest beat leaves the engine reinitialized
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (out_idx_q == LastOut)
      |=> (state_q == ST_IDLE) && (bit_len_q == '0) && (fill_q == '0) && !msg_end_q)
    else $error("engine not reinitialized after digest");

endmodule

`default_nettype wire
